>>> rtl/core/msjd_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-server job dispatcher: item types, job record,
// event and command codes, FSM states and the queue ordering function.
// No dependencies.
`default_nettype none
package msjd_pkg;

	localparam int DEF_QUEUE_DEPTH    = 64;
	localparam int DEF_MAX_PROCESSORS = 4;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [2:0] EV_ACCEPTED = 3'd0;
	localparam logic [2:0] EV_DROPPED  = 3'd1;
	localparam logic [2:0] EV_FINISHED = 3'd2;
	localparam logic [2:0] EV_STARTED  = 3'd3;
	localparam logic [2:0] EV_TICK_END = 3'd4;

	typedef struct packed {
		logic [7:0]  jtype;
		logic [15:0] arrival;
		logic [15:0] ptime;
		logic [15:0] number;
	} job_t;

	typedef struct packed {
		logic        command;
		logic [7:0]  job_type;
		logic [15:0] arrival_time;
		logic [15:0] processing_time;
		logic [15:0] job_number;
	} in_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [1:0]  processor_index;
		logic [15:0] out_job_number;
		logic [7:0]  out_job_type;
		logic [15:0] out_processing_time;
		logic [15:0] event_time;
		logic        last;
	} out_t;

	// shift controls broadcast along the row of queue cells
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_FIN,
		ST_START,
		ST_END
	} state_t;

	// true when a stays ahead of b
	function automatic logic not_after(input job_t a, input job_t b);
		if (a.arrival != b.arrival) begin
			return a.arrival < b.arrival;
		end
		return a.jtype <= b.jtype;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/msjd_cell.sv
`timescale 1ns / 1ps
// One cell of the ordered job queue: holds one job, shifts left on pop,
// opens a gap and takes the new job on insert. Depends on msjd_pkg.
`default_nettype none
module msjd_cell (
	input  wire                  clk,
	input  msjd_pkg::cell_ctl_t  ctl,
	input  wire                  occ,
	input  msjd_pkg::job_t       new_job,
	input  msjd_pkg::job_t       left_job,
	input  wire                  left_keep,
	input  msjd_pkg::job_t       right_job,
	output msjd_pkg::job_t       job,
	output logic                 keep
);

	msjd_pkg::job_t job_q;

	assign job  = job_q;
	// this entry stays in place on insert
	assign keep = occ && msjd_pkg::not_after(job_q, new_job);

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			job_q <= right_job;
		end else if (ctl.ins && !keep) begin
			job_q <= left_keep ? new_job : left_job;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/multi_server_job_dispatcher.sv
`timescale 1ns / 1ps
// Push: item accepted in ST_IDLE, then its single event item is registered in ST_PUSH.
// Tick: per visited processor a finish check (ST_FIN), then a start check (ST_START),
// plus accept and the tick-end event. One item at a time; evt_stall holds each step.
// arst_n clears the queue count, processor busy flags, clock and FSM; count 4 processors.
// Depends on msjd_pkg and msjd_cell.
`default_nettype none
module multi_server_job_dispatcher #(
	parameter int QUEUE_DEPTH    = msjd_pkg::DEF_QUEUE_DEPTH,
	parameter int MAX_PROCESSORS = msjd_pkg::DEF_MAX_PROCESSORS
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [2:0]        cfg_wdata,
	input  wire              job_valid,
	output logic             job_stall,
	input  msjd_pkg::in_t    job,
	output logic             evt_valid,
	input  wire              evt_stall,
	output msjd_pkg::out_t   evt
);

	localparam int QW  = $clog2(QUEUE_DEPTH + 1);
	localparam int CW  = $clog2(MAX_PROCESSORS + 1);
	localparam int PIW = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;

	// control state
	msjd_pkg::state_t state_q, state_d;
	logic [2:0]    act_cfg_q;
	logic [QW-1:0] cnt_q;
	logic [15:0]   cur_q;
	logic [CW-1:0] pcnt_q, act_q;
	logic [MAX_PROCESSORS-1:0] busy_q;
	logic          evt_valid_q;

	// payload
	msjd_pkg::in_t  item_q;
	msjd_pkg::out_t evt_q;
	msjd_pkg::job_t pjob_q [MAX_PROCESSORS];
	logic [15:0]    pstart_q [MAX_PROCESSORS];

	// queue row
	msjd_pkg::job_t cjob [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] ckeep;
	msjd_pkg::cell_ctl_t ctl;
	msjd_pkg::job_t new_job;

	logic [CW-1:0]  act_sat;
	logic [PIW-1:0] pidx;
	logic ofree, full, fin_go, start_go, emit;
	msjd_pkg::out_t emit_evt;
	logic in_acc;

	assign in_acc    = job_valid && !job_stall;
	assign job_stall = (state_q != msjd_pkg::ST_IDLE);
	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;
	// output slot is free when empty or being taken this edge
	assign ofree     = !evt_valid_q || !evt_stall;
	assign full      = (cnt_q == QW'(QUEUE_DEPTH));
	assign pidx      = pcnt_q[PIW-1:0];

	assign new_job.jtype   = item_q.job_type;
	assign new_job.arrival = item_q.arrival_time;
	assign new_job.ptime   = item_q.processing_time;
	assign new_job.number  = item_q.job_number;

	// saturate the processor count to the number built
	always_comb begin
		if (32'(act_cfg_q) > 32'(MAX_PROCESSORS)) begin
			act_sat = CW'(MAX_PROCESSORS);
		end else begin
			act_sat = CW'(act_cfg_q);
		end
	end

	// finish: elapsed time reached; the clock never runs behind a start time
	assign fin_go   = busy_q[pidx] &&
		((cur_q - pstart_q[pidx]) >= pjob_q[pidx].ptime);
	// start: idle, queue not empty and head job already arrived
	assign start_go = !busy_q[pidx] && (cnt_q != '0) && (cjob[0].arrival <= cur_q);

	// queue cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		msjd_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (QW'(i) < cnt_q),
			.new_job   (new_job),
			.left_job  ((i == 0) ? new_job : cjob[(i == 0) ? 0 : i - 1]),
			.left_keep ((i == 0) ? 1'b1 : ckeep[(i == 0) ? 0 : i - 1]),
			.right_job (cjob[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
			.job       (cjob[i]),
			.keep      (ckeep[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			msjd_pkg::ST_IDLE: begin
				if (job_valid) begin
					if (job.command == msjd_pkg::CMD_PUSH) begin
						state_d = msjd_pkg::ST_PUSH;
					end else if (act_sat == '0) begin
						state_d = msjd_pkg::ST_END;
					end else begin
						state_d = msjd_pkg::ST_FIN;
					end
				end
			end
			msjd_pkg::ST_PUSH: begin
				if (ofree) state_d = msjd_pkg::ST_IDLE;
			end
			msjd_pkg::ST_FIN: begin
				if (ofree) state_d = msjd_pkg::ST_START;
			end
			msjd_pkg::ST_START: begin
				if (ofree) begin
					state_d = (pcnt_q + 1'b1 == act_q) ? msjd_pkg::ST_END : msjd_pkg::ST_FIN;
				end
			end
			msjd_pkg::ST_END: begin
				if (ofree) state_d = msjd_pkg::ST_IDLE;
			end
			default: state_d = msjd_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer: event to register and queue controls
	always_comb begin
		emit     = 1'b0;
		ctl      = '0;
		emit_evt = '0;
		emit_evt.event_time = cur_q;
		unique case (state_q)
			msjd_pkg::ST_PUSH: begin
				emit = ofree;
				ctl.ins = ofree && !full;
				emit_evt.event_kind = full ? msjd_pkg::EV_DROPPED : msjd_pkg::EV_ACCEPTED;
				emit_evt.out_job_number      = item_q.job_number;
				emit_evt.out_job_type        = item_q.job_type;
				emit_evt.out_processing_time = item_q.processing_time;
				emit_evt.last = 1'b1;
			end
			msjd_pkg::ST_FIN: begin
				emit = ofree && fin_go;
				emit_evt.event_kind      = msjd_pkg::EV_FINISHED;
				emit_evt.processor_index = 2'(pcnt_q);
				emit_evt.out_job_number      = pjob_q[pidx].number;
				emit_evt.out_job_type        = pjob_q[pidx].jtype;
				emit_evt.out_processing_time = pjob_q[pidx].ptime;
			end
			msjd_pkg::ST_START: begin
				emit = ofree && start_go;
				ctl.pop = ofree && start_go;
				emit_evt.event_kind      = msjd_pkg::EV_STARTED;
				emit_evt.processor_index = 2'(pcnt_q);
				emit_evt.out_job_number      = cjob[0].number;
				emit_evt.out_job_type        = cjob[0].jtype;
				emit_evt.out_processing_time = cjob[0].ptime;
			end
			msjd_pkg::ST_END: begin
				emit = ofree;
				emit_evt.event_kind = msjd_pkg::EV_TICK_END;
				emit_evt.last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msjd_pkg::ST_IDLE;
			act_cfg_q   <= 3'd4;
			cnt_q       <= '0;
			cur_q       <= '0;
			pcnt_q      <= '0;
			act_q       <= '0;
			busy_q      <= '0;
			evt_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) act_cfg_q <= cfg_wdata;
			if (in_acc) begin
				pcnt_q <= '0;
				act_q  <= act_sat;
			end
			if (ctl.ins) cnt_q <= cnt_q + 1'b1;
			if (ctl.pop) cnt_q <= cnt_q - 1'b1;
			// drop the busy flag on finish, raise it on start
			if (state_q == msjd_pkg::ST_FIN && ofree && fin_go) busy_q[pidx] <= 1'b0;
			if (state_q == msjd_pkg::ST_START && ofree) begin
				if (start_go) busy_q[pidx] <= 1'b1;
				pcnt_q <= pcnt_q + 1'b1;
			end
			// advance the clock at tick end, holding at its maximum
			if (state_q == msjd_pkg::ST_END && ofree && cur_q != 16'hFFFF) begin
				cur_q <= cur_q + 16'd1;
			end
			if (emit) begin
				evt_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) item_q <= job;
		if (emit) evt_q <= emit_evt;
		if (ctl.pop) begin
			pjob_q[pidx]   <= cjob[0];
			pstart_q[pidx] <= cur_q;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop did not lower the count");

	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q >= $past(cur_q))
		else $error("clock went backwards");

	a_busy_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> busy_q[$past(pidx)])
		else $error("started processor not busy");
`endif

endmodule
`default_nettype wire
